// File: hdl/ldw_pkg.sv
package ldw_pkg;

  // Binary width of the number field and the BCD digits it converts into.
  localparam int BIN_W      = 20;
  localparam int BCD_DIGITS = 7;
  localparam int BCD_W      = 4 * BCD_DIGITS;

  // Segment memory geometry.
  localparam int ROWS      = 4;
  localparam int ROW_BYTES = 3;
  localparam int MEM_BYTES = ROWS * ROW_BYTES;
  localparam int POSITIONS = 6;

  localparam logic [2:0] LAST_POS  = 3'(POSITIONS - 1);
  localparam logic [3:0] MAX_DIGIT = 4'd9;

  localparam logic ACT_NUMBER = 1'b0;
  localparam logic ACT_DIGIT  = 1'b1;

  typedef logic [MEM_BYTES-1:0][7:0] seg_mem_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_WRITE,
    ST_DONE
  } ldw_state_t;

  // Row nibbles of one digit glyph, row 0 in the low nibble.
  function automatic logic [15:0] glyph_rows(input logic [3:0] d);
    logic [15:0] g;
    case (d)
      4'd0:    g = {4'h1, 4'h5, 4'h5, 4'h1};
      4'd1:    g = {4'h0, 4'h1, 4'h1, 4'h8};
      4'd2:    g = {4'h1, 4'hE, 4'h1, 4'h1};
      4'd3:    g = {4'h1, 4'hB, 4'h1, 4'h1};
      4'd4:    g = {4'h0, 4'hB, 4'h5, 4'h0};
      4'd5:    g = {4'h1, 4'hB, 4'h4, 4'h1};
      4'd6:    g = {4'h1, 4'hF, 4'h4, 4'h1};
      4'd7:    g = {4'h0, 4'h1, 4'h1, 4'h1};
      4'd8:    g = {4'h1, 4'hF, 4'h5, 4'h1};
      4'd9:    g = {4'h1, 4'hB, 4'h5, 4'h1};
      default: g = 16'h0000;
    endcase
    return g;
  endfunction

endpackage

// File: hdl/ldw_if.sv
// Input request channel.
interface ldw_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [19:0] number;
  logic [3:0]  digit;
  logic [2:0]  position;

  modport source(output valid, output action, output number, output digit,
                 output position, input ready);
  modport sink(input valid, input action, input number, input digit,
               input position, output ready);
endinterface

// Result channel: the whole segment memory after one request.
interface ldw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] row0_byte0;
  logic [7:0] row0_byte1;
  logic [7:0] row0_byte2;
  logic [7:0] row1_byte0;
  logic [7:0] row1_byte1;
  logic [7:0] row1_byte2;
  logic [7:0] row2_byte0;
  logic [7:0] row2_byte1;
  logic [7:0] row2_byte2;
  logic [7:0] row3_byte0;
  logic [7:0] row3_byte1;
  logic [7:0] row3_byte2;

  modport source(output valid, input ready,
                 output row0_byte0, output row0_byte1, output row0_byte2,
                 output row1_byte0, output row1_byte1, output row1_byte2,
                 output row2_byte0, output row2_byte1, output row2_byte2,
                 output row3_byte0, output row3_byte1, output row3_byte2);
  modport sink(input valid, output ready,
               input row0_byte0, input row0_byte1, input row0_byte2,
               input row1_byte0, input row1_byte1, input row1_byte2,
               input row2_byte0, input row2_byte1, input row2_byte2,
               input row3_byte0, input row3_byte1, input row3_byte2);
endinterface

// File: hdl/ldw_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add three), one bit a cycle.
module ldw_bcd_conv (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ldw_pkg::BIN_W-1:0] bin_in,
  output logic                     last,
  output logic [ldw_pkg::BCD_W-1:0] bcd
);
  import ldw_pkg::*;

  localparam int CNT_W = $clog2(BIN_W + 1);

  logic [BIN_W-1:0] bin_r;
  logic [BCD_W-1:0] bcd_r;
  logic [BCD_W-1:0] adj;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  // Correct every digit that would overflow on the next doubling.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // Control: count the remaining bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(BIN_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath: shift the next binary bit into the corrected digits.
  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= bin_in;
      bcd_r <= '0;
    end else if (busy_r) begin
      bin_r <= {bin_r[BIN_W-2:0], 1'b0};
      bcd_r <= {adj[BCD_W-2:0], bin_r[BIN_W-1]};
    end
  end

  assign last = busy_r && (cnt_r == CNT_W'(1));
  assign bcd  = bcd_r;

endmodule

// File: hdl/ldw_seg_mem.sv
// Segment memory: writes the four row nibbles of one position per cycle while we is high.
module ldw_seg_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [2:0]        pos,
  input  logic [3:0]        dig,
  output ldw_pkg::seg_mem_t mem
);
  import ldw_pkg::*;

  seg_mem_t    mem_r;
  logic [15:0] glyph;
  logic [3:0]  idx [ROWS];

  assign glyph = glyph_rows(dig);

  // Byte of each row that holds the position.
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      idx[r] = 4'(r * ROW_BYTES) + {2'b00, pos[2:1]};
    end
  end

  // Odd positions take the high nibble, even positions the low nibble.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_r <= '0;
    end else if (we) begin
      for (int r = 0; r < ROWS; r++) begin
        if (pos[0]) begin
          mem_r[idx[r]][7:4] <= glyph[4*r +: 4];
        end else begin
          mem_r[idx[r]][3:0] <= glyph[4*r +: 4];
        end
      end
    end
  end

  assign mem = mem_r;

endmodule

// File: hdl/decimal_lcd_digit_writer.sv
// Channel | Dir | Payload                               | Handshake
// in_ch   | in  | action, number, digit, position       | valid/ready
// out_ch  | out | row0_byte0 .. row3_byte2 (12 bytes)   | valid/ready
//
// Number request: accepted, then converted (the converter is loaded, then takes one bit
// a cycle through the shift and add-three unit), then one to six digits are written,
// then the output register is loaded. Digit request: accepted, written, then loaded.
// Reset is synchronous, active low, and clears the segment memory to zero.
// A result waits in the output register; the next request is accepted and
// worked on meanwhile, and only its final output load waits for out_ch.ready.
module decimal_lcd_digit_writer (
  input logic   clk,
  input logic   rst_n,
  ldw_in_if.sink    in_ch,
  ldw_out_if.source out_ch
);
  import ldw_pkg::*;

  ldw_state_t state_r, state_nxt;

  logic             action_r;
  logic [BIN_W-1:0] number_r;
  logic [3:0]       digit_r;
  logic [2:0]       pos_r;
  logic [2:0]       k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  seg_mem_t         out_r;

  logic             in_fire;
  logic             conv_start;
  logic             conv_last;
  logic [BCD_W-1:0] bcd;
  logic [2:0]       last_k;
  logic             we;
  logic [2:0]       wr_pos;
  logic [3:0]       wr_dig;
  logic             load_out;
  seg_mem_t         mem;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      action_r <= in_ch.action;
      number_r <= in_ch.number;
      digit_r  <= in_ch.digit;
      pos_r    <= in_ch.position;
    end
  end

  ldw_bcd_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (conv_start),
    .bin_in (number_r),
    .last   (conv_last),
    .bcd    (bcd)
  );

  // Index of the leftmost digit to write, ones digit being zero.
  always_comb begin
    last_k = 3'd0;
    for (int i = 1; i < POSITIONS - 1; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        last_k = 3'(i);
      end
    end
    if (bcd[4*(POSITIONS-1) +: 4] != 4'd0 || bcd[4*POSITIONS +: 4] != 4'd0) begin
      last_k = LAST_POS;
    end
  end

  // Write port: a digit request's own position, or number digit k at five minus k.
  always_comb begin
    if (action_r == ACT_DIGIT) begin
      wr_pos = pos_r;
      wr_dig = digit_r;
    end else begin
      wr_pos = LAST_POS - k_r;
      wr_dig = bcd[{k_r, 2'b00} +: 4];
    end
  end

  ldw_seg_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we),
    .pos   (wr_pos),
    .dig   (wr_dig),
    .mem   (mem)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequencer next state and controls.
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    conv_start    = 1'b0;
    we            = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        k_nxt = 3'd0;
        if (in_fire) begin
          state_nxt = (in_ch.action == ACT_DIGIT) ? ST_WRITE : ST_CONV;
        end
      end
      ST_CONV: begin
        conv_start = (k_r == 3'd0);
        k_nxt      = 3'd1;
        if (conv_last) begin
          k_nxt     = 3'd0;
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (action_r == ACT_DIGIT) begin
          we        = (digit_r <= MAX_DIGIT) && (pos_r <= LAST_POS);
          state_nxt = ST_DONE;
        end else begin
          we    = 1'b1;
          k_nxt = k_r + 3'd1;
          if (k_r == last_k) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register holds the memory image until it is taken.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= mem;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.row0_byte0 = out_r[0];
  assign out_ch.row0_byte1 = out_r[1];
  assign out_ch.row0_byte2 = out_r[2];
  assign out_ch.row1_byte0 = out_r[3];
  assign out_ch.row1_byte1 = out_r[4];
  assign out_ch.row1_byte2 = out_r[5];
  assign out_ch.row2_byte0 = out_r[6];
  assign out_ch.row2_byte1 = out_r[7];
  assign out_ch.row2_byte2 = out_r[8];
  assign out_ch.row3_byte0 = out_r[9];
  assign out_ch.row3_byte1 = out_r[10];
  assign out_ch.row3_byte2 = out_r[11];

endmodule
